// ===== design/assert_macros.svh =====
// Assertion macros shared by the heap priority queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// Condition that must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/hpq_pkg.sv =====
// Package for the heap priority queue: request/result structs, entry type and codes.
// No dependencies; imported by the compare unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Width of the reported entry count
    localparam int ENTRY_TOTAL_W = 11;

    // Top value reported when the heap is empty
    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    // One request
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] priority_req;
        logic signed [31:0] value;
    } t_req;

    // One result
    typedef struct packed {
        logic signed [31:0]        top_value;
        logic                      top_valid;
        logic [ENTRY_TOTAL_W-1:0]  entry_total;
        logic                      op_error;
    } t_rsp;

    // One stored heap entry
    typedef struct packed {
        logic signed [31:0] prio;
        logic signed [31:0] val;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Compare unit verdict
    typedef struct packed {
        logic pick_b;   // second candidate wins
        logic item_ge;  // moving entry >= winning candidate
    } t_cmp_res;

endpackage

`default_nettype wire

// ===== design/hpq_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies; holds the heap entries.
`timescale 1ns / 1ps
`default_nettype none

module hpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic      [WIDTH-1:0]           o_rdata_a,
    output logic      [WIDTH-1:0]           o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== design/hpq_cmp.sv =====
// Shared priority compare unit, used by both the sift-up and the sift-down walk.
// Depends on hpq_pkg for the verdict struct.
`timescale 1ns / 1ps
`default_nettype none

module hpq_cmp import hpq_pkg::*; (
    input  wire logic signed [31:0] i_item_prio,
    input  wire logic signed [31:0] i_a_prio,
    input  wire logic signed [31:0] i_b_prio,
    input  wire logic               i_b_valid,
    output t_cmp_res                o_res
);

    logic signed [31:0] win_prio;

    // Second candidate only when present and strictly greater
    assign o_res.pick_b = i_b_valid && (i_a_prio < i_b_prio);
    assign win_prio     = o_res.pick_b ? i_b_prio : i_a_prio;

    // Moving entry against the winning candidate
    assign o_res.item_ge = (i_item_prio >= win_prio);

endmodule

`default_nettype wire

// ===== design/binary_max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue: sequencer, entry RAM and shared compare unit.
// Depends on hpq_pkg, hpq_ram, hpq_cmp and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// A request is taken when start is high and busy is low; busy then stays high until
// the result has been shown. The result sits on o_rsp for exactly one cycle with o_done
// high and cannot be held off, so it must be captured in that cycle. A refused request
// (insert when full, remove when empty) and a remove that takes the last entry answer in
// the cycle right after acceptance. Otherwise the walk moves at most ceil(log2(CAPACITY))
// entries; a remove first loads the last entry (S_LOAD), and each level of the walk then
// costs a RAM read state (S_READ) and a compare/write state (S_CMP) through the shared
// compare unit, followed by the final write (S_PUT) and the result (S_DONE).
// The entry RAM needs no clearing after reset: only entries below the count are read.
module binary_max_heap_priority_queue_unit import hpq_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = AW + 2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_READ = 6'b000100,
        S_CMP  = 6'b001000,
        S_PUT  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_pos, n_pos;
    logic [AW-1:0]   r_kid, n_kid;
    t_entry          r_item, n_item;
    logic            r_up, n_up;
    logic            r_err, n_err;
    logic            r_bvalid, n_bvalid;
    logic signed [31:0] r_root_val;

    logic            accept;
    logic            full;
    logic            empty;
    logic [CW-1:0]   cnt_m1;
    logic [AW-1:0]   parent;
    logic [KW-1:0]   kid_w;
    logic [KW-1:0]   kid_r;
    logic [KW-1:0]   cnt_w;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    logic [ENTRY_W-1:0] rdata_a;
    logic [ENTRY_W-1:0] rdata_b;
    t_entry          rd_a;
    t_entry          rd_b;
    t_entry          chosen;
    logic [AW-1:0]   chosen_idx;
    t_cmp_res        cmp;
    logic            we;
    logic [AW-1:0]   waddr;
    t_entry          wdata;
    logic [ENTRY_TOTAL_W+CW-1:0] total_wide;

    // Handshake and count status
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_count == CW'(CAPACITY));
    assign empty  = (r_count == '0);
    assign cnt_m1 = r_count - CW'(1);

    // Tree index arithmetic
    assign parent = (r_pos - AW'(1)) >> 1;
    assign kid_w  = {1'b0, r_pos, 1'b1};
    assign kid_r  = kid_w + KW'(1);
    assign cnt_w  = KW'(r_count);

    // RAM read addresses: last entry while idle, parent or children during a walk
    always_comb begin
        if (r_state == S_IDLE) begin
            raddr_a = cnt_m1[AW-1:0];
        end else if (r_up) begin
            raddr_a = parent;
        end else begin
            raddr_a = kid_w[AW-1:0];
        end
    end
    assign raddr_b = kid_r[AW-1:0];

    assign rd_a = rdata_a;
    assign rd_b = rdata_b;

    hpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Shared compare unit: parent on a sift-up, both children on a sift-down
    hpq_cmp u_cmp (
        .i_item_prio (r_item.prio),
        .i_a_prio    (rd_a.prio),
        .i_b_prio    (rd_b.prio),
        .i_b_valid   (r_bvalid && !r_up),
        .o_res       (cmp)
    );

    assign chosen     = cmp.pick_b ? rd_b : rd_a;
    assign chosen_idx = r_kid + AW'(cmp.pick_b);

    // Sequencer: the moving entry is held in r_item and written once at its final slot
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_kid    = r_kid;
        n_item   = r_item;
        n_up     = r_up;
        n_err    = r_err;
        n_bvalid = r_bvalid;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_item;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_INSERT) begin
                        if (full) begin
                            n_err   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_err       = 1'b0;
                            n_up        = 1'b1;
                            n_item.prio = i_req.priority_req;
                            n_item.val  = i_req.value;
                            n_pos       = r_count[AW-1:0];
                            n_count     = r_count + CW'(1);
                            n_state     = empty ? S_PUT : S_READ;
                        end
                    end else begin
                        if (empty) begin
                            n_err   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_err   = 1'b0;
                            n_up    = 1'b0;
                            n_count = cnt_m1;
                            n_state = (cnt_m1 == '0) ? S_DONE : S_LOAD;
                        end
                    end
                end
            end
            S_LOAD: begin
                // last entry arrives from the RAM and becomes the moving entry at the root
                n_item  = rd_a;
                n_pos   = '0;
                n_state = S_READ;
            end
            S_READ: begin
                if (r_up) begin
                    n_state = S_CMP;
                end else if (kid_w >= cnt_w) begin
                    n_state = S_PUT;
                end else begin
                    n_kid    = kid_w[AW-1:0];
                    n_bvalid = (kid_r < cnt_w);
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (r_up) begin
                    // parent moves down while its priority is not above ours
                    if (cmp.item_ge) begin
                        we      = 1'b1;
                        wdata   = rd_a;
                        n_pos   = parent;
                        n_state = (parent == '0) ? S_PUT : S_READ;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    // larger child moves up unless we already dominate it
                    if (cmp.item_ge) begin
                        n_state = S_PUT;
                    end else begin
                        we      = 1'b1;
                        wdata   = chosen;
                        n_pos   = chosen_idx;
                        n_state = S_READ;
                    end
                end
            end
            S_PUT: begin
                we      = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_up     <= 1'b0;
            r_err    <= 1'b0;
            r_bvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_up     <= n_up;
            r_err    <= n_err;
            r_bvalid <= n_bvalid;
        end
    end

    // Walk payload registers
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_kid  <= n_kid;
        r_item <= n_item;
    end

    // Copy of the root value, kept in step with every write to slot zero
    always_ff @(posedge i_clk) begin
        if (we && (waddr == '0)) begin
            r_root_val <= wdata.val;
        end
    end

    // Result
    assign total_wide        = (ENTRY_TOTAL_W + CW)'(r_count);
    assign o_done            = (r_state == S_DONE);
    assign o_rsp.top_value   = empty ? EMPTY_VALUE : r_root_val;
    assign o_rsp.top_valid   = !empty;
    assign o_rsp.entry_total = total_wide[ENTRY_TOTAL_W-1:0];
    assign o_rsp.op_error    = r_err;

    // Checks
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(CAPACITY), "count above capacity")
    `ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, o_done, !busy, "busy held after result")
    `ASSERT_IMPLIES(a_err_keeps, i_clk, i_rst_n, o_done && r_err, r_count == $past(r_count), "refused request changed count")
    `ASSERT_IMPLIES(a_pos_range, i_clk, i_rst_n, r_state == S_CMP || r_state == S_PUT, KW'(r_pos) < cnt_w, "walk slot beyond count")

endmodule

`default_nettype wire
